/* src/kvt_pkg.sv */
// ----------------------------------------------------------------------------
// kvt_pkg
// Shared types, codes and the control store of the key/value table unit.
// ----------------------------------------------------------------------------
package kvt_pkg;

	// input action codes
	localparam logic [1:0] ACT_INSERT = 2'd0;
	localparam logic [1:0] ACT_LOOKUP = 2'd1;
	localparam logic [1:0] ACT_ERASE  = 2'd2;

	// result status codes
	localparam logic [2:0] ST_INSERTED  = 3'd0;
	localparam logic [2:0] ST_PRESENT   = 3'd1;
	localparam logic [2:0] ST_FULL      = 3'd2;
	localparam logic [2:0] ST_FOUND     = 3'd3;
	localparam logic [2:0] ST_NOT_FOUND = 3'd4;
	localparam logic [2:0] ST_ERASED    = 3'd5;

	// control store addresses
	typedef logic [2:0] pc_t;
	localparam pc_t PC_IDLE   = 3'd0;
	localparam pc_t PC_SCAN   = 3'd1;
	localparam pc_t PC_DECIDE = 3'd2;
	localparam pc_t PC_CHKERA = 3'd3;
	localparam pc_t PC_INS_WR = 3'd4;
	localparam pc_t PC_ERA_RD = 3'd5;
	localparam pc_t PC_ERA_WR = 3'd6;
	localparam pc_t PC_FINISH = 3'd7;

	// datapath operation of one step
	typedef enum logic [2:0] {
		OP_CAPTURE = 3'd0,
		OP_SCAN    = 3'd1,
		OP_DECIDE  = 3'd2,
		OP_NONE    = 3'd3,
		OP_INS_WR  = 3'd4,
		OP_RD_LAST = 3'd5,
		OP_MOVE_WR = 3'd6,
		OP_FINISH  = 3'd7
	} op_t;

	// branch condition of one step
	typedef enum logic [2:0] {
		C_ALWAYS    = 3'd0,
		C_ACCEPT    = 3'd1,
		C_SCAN_DONE = 3'd2,
		C_INS_NEW   = 3'd3,
		C_ERA_HIT   = 3'd4,
		C_OUT_FREE  = 3'd5
	} cond_t;

	typedef struct packed {
		op_t   op;
		cond_t cond;
		pc_t   tgt_t;
		pc_t   tgt_f;
	} ctrl_word_t;

	// condition flags from the datapath
	typedef struct packed {
		logic accept;
		logic scan_done;
		logic ins_new;
		logic era_hit;
		logic out_free;
	} cond_flags_t;

	function automatic ctrl_word_t ucode_rom(pc_t pc);
		ctrl_word_t w;
		case (pc)
			PC_IDLE:   w = '{OP_CAPTURE, C_ACCEPT,    PC_SCAN,   PC_IDLE};
			PC_SCAN:   w = '{OP_SCAN,    C_SCAN_DONE, PC_DECIDE, PC_SCAN};
			PC_DECIDE: w = '{OP_DECIDE,  C_INS_NEW,   PC_INS_WR, PC_CHKERA};
			PC_CHKERA: w = '{OP_NONE,    C_ERA_HIT,   PC_ERA_RD, PC_FINISH};
			PC_INS_WR: w = '{OP_INS_WR,  C_ALWAYS,    PC_FINISH, PC_FINISH};
			PC_ERA_RD: w = '{OP_RD_LAST, C_ALWAYS,    PC_ERA_WR, PC_ERA_WR};
			PC_ERA_WR: w = '{OP_MOVE_WR, C_ALWAYS,    PC_FINISH, PC_FINISH};
			PC_FINISH: w = '{OP_FINISH,  C_OUT_FREE,  PC_IDLE,   PC_FINISH};
			default:   w = '{OP_NONE,    C_ALWAYS,    PC_IDLE,   PC_IDLE};
		endcase
		return w;
	endfunction

endpackage

/* src/kvt_ram.sv */
// ----------------------------------------------------------------------------
// kvt_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module kvt_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data_q <= mem_q[rd_addr];
	end

	assign rd_data = rd_data_q;

endmodule

/* src/kvt_sequencer.sv */
// ----------------------------------------------------------------------------
// kvt_sequencer
// Step counter and control store; picks the next step from a branch flag.
// ----------------------------------------------------------------------------
module kvt_sequencer import kvt_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  cond_flags_t flags,
	output ctrl_word_t  ctrl
);

	pc_t  pc_q;
	logic take;

	assign ctrl = ucode_rom(pc_q);

	always_comb begin
		case (ctrl.cond)
			C_ALWAYS:    take = 1'b1;
			C_ACCEPT:    take = flags.accept;
			C_SCAN_DONE: take = flags.scan_done;
			C_INS_NEW:   take = flags.ins_new;
			C_ERA_HIT:   take = flags.era_hit;
			C_OUT_FREE:  take = flags.out_free;
			default:     take = 1'b1;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= PC_IDLE;
		end else begin
			pc_q <= take ? ctrl.tgt_t : ctrl.tgt_f;
		end
	end

endmodule

/* src/key_value_table_unit.sv */
// ----------------------------------------------------------------------------
// key_value_table_unit
// Packed table of unique keys with values; insert, lookup and erase items.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake          | payload
//  ---------+-----------+--------------------+-------------------------------
//  in       | into      | in_valid/in_stall  | action, key, value
//  out      | out of    | out_valid/out_stall| status, found_value, entry_count
//
//  One item at a time. The slot scan issues one table RAM read per occupied
//  slot, stopping at a hit, and then drains the last compare; an erase hit
//  adds a read of the last entry and its move into the freed slot.
//  Reset clears the entry count and control; table RAM contents are not reset.
//  A stalled result holds in the output register; the next item is taken
//  meanwhile and waits in its final step until the register frees.
// ----------------------------------------------------------------------------
module key_value_table_unit import kvt_pkg::*; #(
	parameter int TABLE_DEPTH = 16,
	parameter int KEY_WIDTH   = 32,
	parameter int VALUE_WIDTH = 32
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_stall,
	input  logic [1:0]                       action,
	input  logic [KEY_WIDTH-1:0]             key,
	input  logic [VALUE_WIDTH-1:0]           value,
	output logic                             out_valid,
	input  logic                             out_stall,
	output logic [2:0]                       status,
	output logic [VALUE_WIDTH-1:0]           found_value,
	output logic [$clog2(TABLE_DEPTH+1)-1:0] entry_count
);

	localparam int AW = $clog2(TABLE_DEPTH);
	localparam int CW = $clog2(TABLE_DEPTH + 1);
	localparam int EW = KEY_WIDTH + VALUE_WIDTH;
	localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);

	ctrl_word_t  ctrl;
	cond_flags_t flags;

	logic [1:0]             action_q;
	logic [KEY_WIDTH-1:0]   key_q;
	logic [VALUE_WIDTH-1:0] value_q;
	logic [CW-1:0]          count_q;
	logic [CW-1:0]          idx_q;
	logic                   pend_s1;
	logic [AW-1:0]          pidx_s1;
	logic                   hit_q;
	logic [AW-1:0]          slot_q;
	logic [VALUE_WIDTH-1:0] hv_q;
	logic [2:0]             res_status_q;

	logic                   out_valid_q;
	logic [2:0]             out_status_q;
	logic [VALUE_WIDTH-1:0] out_value_q;
	logic [CW-1:0]          out_count_q;

	logic                   issue;
	logic                   match;
	logic [CW-1:0]          last_idx;
	logic                   wr_en;
	logic [AW-1:0]          wr_addr;
	logic [EW-1:0]          wr_data;
	logic [AW-1:0]          rd_addr;
	logic [EW-1:0]          rd_data;

	kvt_sequencer u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.flags  (flags),
		.ctrl   (ctrl)
	);

	kvt_ram #(
		.WIDTH (EW),
		.DEPTH (TABLE_DEPTH)
	) u_table (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	assign in_stall = (ctrl.op != OP_CAPTURE);

	// scan issues one read per occupied slot, compares in the next cycle
	assign issue    = (ctrl.op == OP_SCAN) && (idx_q < count_q);
	assign match    = pend_s1 && (rd_data[EW-1:VALUE_WIDTH] == key_q);
	assign last_idx = count_q - CW'(1);

	assign rd_addr = (ctrl.op == OP_RD_LAST) ? last_idx[AW-1:0] : idx_q[AW-1:0];
	assign wr_en   = (ctrl.op == OP_INS_WR) || (ctrl.op == OP_MOVE_WR);
	assign wr_addr = (ctrl.op == OP_INS_WR) ? count_q[AW-1:0] : slot_q;
	assign wr_data = (ctrl.op == OP_INS_WR) ? {key_q, value_q} : rd_data;

	assign flags.accept    = in_valid;
	assign flags.scan_done = hit_q || (!pend_s1 && !issue);
	assign flags.ins_new   = (action_q == ACT_INSERT) && !hit_q && (count_q < DEPTH_C);
	assign flags.era_hit   = (action_q == ACT_ERASE) && hit_q;
	assign flags.out_free  = !out_valid_q || !out_stall;

	always_ff @(posedge clk) begin
		if (ctrl.op == OP_CAPTURE && in_valid) begin
			action_q <= action;
			key_q    <= key;
			value_q  <= value;
		end
		if (issue) begin
			pidx_s1 <= idx_q[AW-1:0];
		end
		if (ctrl.op == OP_SCAN && match && !hit_q) begin
			slot_q <= pidx_s1;
			hv_q   <= rd_data[VALUE_WIDTH-1:0];
		end
		if (ctrl.op == OP_DECIDE) begin
			case (action_q)
				ACT_INSERT: res_status_q <= hit_q ? ST_PRESENT :
					(count_q >= DEPTH_C) ? ST_FULL : ST_INSERTED;
				ACT_LOOKUP: res_status_q <= hit_q ? ST_FOUND : ST_NOT_FOUND;
				ACT_ERASE:  res_status_q <= hit_q ? ST_ERASED : ST_NOT_FOUND;
				default:    res_status_q <= ST_NOT_FOUND;
			endcase
		end
		if (ctrl.op == OP_FINISH && flags.out_free) begin
			out_status_q <= res_status_q;
			out_value_q  <= (res_status_q == ST_FOUND) ? hv_q : '0;
			out_count_q  <= count_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			idx_q       <= '0;
			pend_s1     <= 1'b0;
			hit_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			case (ctrl.op)
				OP_CAPTURE: begin
					idx_q   <= '0;
					pend_s1 <= 1'b0;
					hit_q   <= 1'b0;
				end
				OP_SCAN: begin
					pend_s1 <= issue;
					if (issue) begin
						idx_q <= idx_q + CW'(1);
					end
					if (match) begin
						hit_q <= 1'b1;
					end
				end
				OP_INS_WR:  count_q <= count_q + CW'(1);
				OP_MOVE_WR: count_q <= last_idx;
				default: ;
			endcase
			if (ctrl.op == OP_FINISH && flags.out_free) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid   = out_valid_q;
	assign status      = out_status_q;
	assign found_value = out_value_q;
	assign entry_count = out_count_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= DEPTH_C)
		else $error("entry count above table depth");

	a_insert_grows: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.op == OP_INS_WR |=> count_q == $past(count_q) + CW'(1))
		else $error("insert did not grow the count");

	a_move_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.op == OP_MOVE_WR |-> hit_q && ({1'b0, slot_q} < {1'b0, count_q}))
		else $error("erase move outside occupied slots");

	a_value_only_found: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != ST_FOUND |-> found_value == '0)
		else $error("value reported without a hit");

endmodule

/* test/key_value_table_unit_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// key_value_table_unit_tb
// Sends insert, lookup, erase and unused-action items to the key/value
// table. Each accepted item is replayed on a local table to get the
// expected status, value and count, and each result is checked against it.
// Both sides idle in random bursts; one phase holds the output off for a
// long stretch so that the unit fills up and stalls its input.
// ----------------------------------------------------------------------------
module key_value_table_unit_tb import kvt_pkg::*;;

	localparam int DEPTH       = 16;
	localparam int KEY_W       = 32;
	localparam int VAL_W       = 32;
	localparam int CNT_W       = $clog2(DEPTH + 1);
	localparam int KEY_POOL    = 24;
	localparam int HOLD_CYCLES = 300;
	localparam int TAIL_CYCLES = 40;
	localparam int CYCLE_LIMIT = 400000;

	// action code the unit treats as a no-op
	localparam logic [1:0] ACT_NOOP = 2'd3;

	typedef struct packed {
		logic [2:0]       status;
		logic [VAL_W-1:0] found_value;
		logic [CNT_W-1:0] entry_count;
	} table_result_t;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             in_valid = 1'b0;
	logic             in_stall;
	logic [1:0]       action = ACT_INSERT;
	logic [KEY_W-1:0] key = '0;
	logic [VAL_W-1:0] value = '0;
	logic             out_valid;
	logic             out_stall = 1'b0;
	logic [2:0]       status;
	logic [VAL_W-1:0] found_value;
	logic [CNT_W-1:0] entry_count;

	// local copy of the table
	logic [KEY_W-1:0] tbl_keys [DEPTH];
	logic [VAL_W-1:0] tbl_vals [DEPTH];
	int               tbl_count = 0;

	table_result_t    pending_results [$];
	logic [KEY_W-1:0] key_pool [KEY_POOL];

	int unsigned cycle_count = 0;
	int unsigned error_count = 0;
	bit          src_idle_on = 1'b1;
	bit          rx_idle_on = 1'b1;
	int unsigned hold_requests = 0;
	int unsigned hold_seen = 0;
	int unsigned hold_left = 0;
	int unsigned rx_burst = 0;

	key_value_table_unit #(
		.TABLE_DEPTH(DEPTH),
		.KEY_WIDTH  (KEY_W),
		.VALUE_WIDTH(VAL_W)
	) i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.action     (action),
		.key        (key),
		.value      (value),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.status     (status),
		.found_value(found_value),
		.entry_count(entry_count)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results pending", cycle_count,
				pending_results.size());
			$display("RESULT: ERROR");
			$finish;
		end
	end

	task automatic report_mismatch(input string msg);
		$display("mismatch at cycle %0d: %s", cycle_count, msg);
		error_count++;
	endtask

	// Applies one item to the local table and returns the result it yields.
	function automatic table_result_t apply_table_op(logic [1:0] act, logic [KEY_W-1:0] k,
			logic [VAL_W-1:0] v);
		table_result_t r;
		int            slot;
		r.status      = ST_NOT_FOUND;
		r.found_value = '0;
		slot          = -1;
		for (int s = 0; s < tbl_count; s++)
			if (slot < 0 && tbl_keys[s] == k)
				slot = s;
		case (act)
			ACT_INSERT: begin
				if (slot >= 0)
					r.status = ST_PRESENT;
				else if (tbl_count >= DEPTH)
					r.status = ST_FULL;
				else begin
					tbl_keys[tbl_count] = k;
					tbl_vals[tbl_count] = v;
					tbl_count++;
					r.status = ST_INSERTED;
				end
			end
			ACT_LOOKUP: begin
				if (slot >= 0) begin
					r.status      = ST_FOUND;
					r.found_value = tbl_vals[slot];
				end
			end
			ACT_ERASE: begin
				// last entry moves into the freed slot
				if (slot >= 0) begin
					tbl_keys[slot] = tbl_keys[tbl_count - 1];
					tbl_vals[slot] = tbl_vals[tbl_count - 1];
					tbl_count--;
					r.status = ST_ERASED;
				end
			end
			default: ;
		endcase
		r.entry_count = CNT_W'(tbl_count);
		return r;
	endfunction

	// result check, then prediction for the item taken at this edge
	always @(posedge clk) begin
		table_result_t exp_r;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_results.size() == 0)
				report_mismatch($sformatf("unexpected result status=%0d", status));
			else begin
				exp_r = pending_results.pop_front();
				if (status !== exp_r.status)
					report_mismatch($sformatf("status %0d, expected %0d", status,
						exp_r.status));
				if (found_value !== exp_r.found_value)
					report_mismatch($sformatf("found_value %h, expected %h", found_value,
						exp_r.found_value));
				if (entry_count !== exp_r.entry_count)
					report_mismatch($sformatf("entry_count %0d, expected %0d", entry_count,
						exp_r.entry_count));
			end
		end
		if (arst_n && in_valid && !in_stall)
			pending_results.push_back(apply_table_op(action, key, value));
	end

	// receiver: random stall bursts, plus a long hold on request
	always @(negedge clk) begin
		if (hold_requests != hold_seen) begin
			hold_seen <= hold_requests;
			hold_left <= HOLD_CYCLES;
			out_stall <= 1'b1;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			out_stall <= 1'b1;
		end else if (rx_burst != 0) begin
			rx_burst  <= rx_burst - 1;
			out_stall <= 1'b1;
		end else if (rx_idle_on && $urandom_range(0, 5) == 0) begin
			rx_burst  <= $urandom_range(0, 8);
			out_stall <= 1'b1;
		end else begin
			out_stall <= 1'b0;
		end
	end

	// Called and returns at a falling edge; valid stays high between items.
	task automatic send_item(input logic [1:0] act, input logic [KEY_W-1:0] k,
			input logic [VAL_W-1:0] v);
		if (src_idle_on && $urandom_range(0, 4) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 9)) @(negedge clk);
		end
		in_valid <= 1'b1;
		action   <= act;
		key      <= k;
		value    <= v;
		do
			@(posedge clk);
		while (in_stall);
		@(negedge clk);
	endtask

	task automatic send_random_op(input int insert_pct);
		int               pick;
		logic [1:0]       act;
		logic [KEY_W-1:0] k;
		pick = $urandom_range(0, 99);
		if (pick < insert_pct)
			act = ACT_INSERT;
		else if (pick < insert_pct + (95 - insert_pct) / 2)
			act = ACT_LOOKUP;
		else if (pick < 95)
			act = ACT_ERASE;
		else
			act = ACT_NOOP;
		// mostly pool keys so that hits, duplicates and a full table occur
		if ($urandom_range(0, 6) == 0)
			k = $urandom;
		else
			k = key_pool[$urandom_range(0, KEY_POOL - 1)];
		if ($urandom_range(0, 19) == 0)
			key_pool[$urandom_range(2, KEY_POOL - 1)] = $urandom;
		send_item(act, k, $urandom);
	endtask

	task automatic test_basic_ops;
		send_item(ACT_LOOKUP, '0, '1);
		send_item(ACT_INSERT, '0, '1);
		send_item(ACT_INSERT, '1, '0);
		send_item(ACT_INSERT, '0, 32'h1234_5678);
		send_item(ACT_LOOKUP, '0, '0);
		send_item(ACT_NOOP, '0, '1);
		send_item(ACT_ERASE, '0, '0);
		send_item(ACT_LOOKUP, '1, '1);
		send_item(ACT_ERASE, '0, '0);
	endtask

	task automatic test_full_table;
		for (int i = 1; i < DEPTH; i++)
			send_item(ACT_INSERT, KEY_W'(32'hA5A5_0000 + i), $urandom);
		send_item(ACT_INSERT, 32'h5A5A_5A5A, $urandom);
		// present key wins over full
		send_item(ACT_INSERT, '1, $urandom);
		send_item(ACT_ERASE, KEY_W'(32'hA5A5_0003), '0);
		send_item(ACT_LOOKUP, KEY_W'(32'hA5A5_000F), '0);
	endtask

	task automatic test_random_mix(input int n_items);
		int insert_pct;
		insert_pct = 50;
		key_pool[0] = '0;
		key_pool[1] = '1;
		for (int i = 2; i < KEY_POOL; i++)
			key_pool[i] = $urandom;
		for (int i = 0; i < n_items; i++) begin
			// drift between filling and draining phases
			if (i % 50 == 0)
				insert_pct = $urandom_range(20, 70);
			if (i % 200 == 0) begin
				src_idle_on = ($urandom_range(0, 3) != 0);
				rx_idle_on  = ($urandom_range(0, 3) != 0);
			end
			send_random_op(insert_pct);
		end
		src_idle_on = 1'b1;
		rx_idle_on  = 1'b1;
	endtask

	task automatic test_backpressure;
		src_idle_on = 1'b0;
		rx_idle_on  = 1'b0;
		hold_requests <= hold_requests + 1;
		for (int i = 0; i < 12; i++)
			send_random_op(40);
		src_idle_on = 1'b1;
		rx_idle_on  = 1'b1;
	endtask

	task automatic test_streaming(input int n_items);
		src_idle_on = 1'b0;
		rx_idle_on  = 1'b0;
		for (int i = 0; i < n_items; i++)
			send_random_op(45);
	endtask

	initial begin
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		test_basic_ops();
		test_full_table();
		test_random_mix(1100);
		test_backpressure();
		test_streaming(160);
		in_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (error_count == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
